/* src/lzr_pkg.sv */
// lzr_pkg: shared constants, types and codes for the lzss/rle stream decoder
// used by lzr_fill, lzr_pack and lzss_rle_stream_decoder; no dependencies
package lzr_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int WIN_AW      = 12;
	localparam int OUT_LANES   = 8;
	localparam int OUT_W       = OUT_LANES * 8;
	localparam int CNT_W       = 4;
	localparam int LEN_W       = 9;

	localparam int MAX_COPY_V1 = 18;
	localparam int MAX_COPY_V3 = 17;

	localparam logic [WIN_AW-1:0] WP_START_V1 = WIN_AW'(WINDOW_SIZE - MAX_COPY_V1);
	localparam logic [WIN_AW-1:0] WP_START_V3 = WIN_AW'(WINDOW_SIZE - MAX_COPY_V3);

	localparam logic [15:0] FLAG_FILL = 16'hff00;
	localparam logic [3:0]  RUN_CODE  = 4'hf;

	// parser phase codes
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_TOKEN  = 2'd1;
	localparam logic [1:0] PH_FIRST  = 2'd2;
	localparam logic [1:0] PH_SECOND = 2'd3;

	typedef enum logic [5:0] {
		S_FILL  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_RUN   = 6'b000100,
		S_CRD   = 6'b001000,
		S_CWR   = 6'b010000,
		S_FLUSH = 6'b100000
	} dec_state_t;

	// sequencer to packer
	typedef struct packed {
		logic       push;
		logic [7:0] data;
		logic       flush;
		logic       last;
	} pack_ctl_t;

	// packer to sequencer
	typedef struct packed {
		logic full;
		logic out_free;
	} pack_sts_t;

endpackage

/* src/lzr_ram.sv */
// lzr_ram: generic simple dual-port ram, one write and one registered read port
// read-first on an address collision; no dependencies
module lzr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/lzr_fill.sv */
// lzr_fill: sweeps the history window once, writing its preset byte pattern
// depends on lzr_pkg
module lzr_fill (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	output logic [lzr_pkg::WIN_AW-1:0] addr,
	output logic [7:0]                data
);
	import lzr_pkg::*;

	logic [WIN_AW-1:0] fa_q;
	logic [7:0]        fn_q;
	logic [2:0]        fr_q;
	logic              busy_q;

	// low half: n,0 pairs; then groups of seven n,ff,..,n; top 256 bytes zero
	always_comb begin
		if (!fa_q[WIN_AW-1]) begin
			data = fa_q[0] ? 8'h00 : fa_q[10:3];
		end else if (fa_q[WIN_AW-1 -: 4] == 4'hf) begin
			data = 8'h00;
		end else begin
			data = fr_q[0] ? 8'hff : fn_q;
		end
	end

	assign addr = fa_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_q   <= '0;
			fn_q   <= '0;
			fr_q   <= '0;
			busy_q <= 1'b1;
		end else if (start) begin
			fa_q   <= '0;
			fn_q   <= '0;
			fr_q   <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			fa_q <= fa_q + 1'b1;
			if (fa_q[WIN_AW-1]) begin
				if (fr_q == 3'd6) begin
					fr_q <= '0;
					fn_q <= fn_q + 1'b1;
				end else begin
					fr_q <= fr_q + 1'b1;
				end
			end
			if (fa_q == {WIN_AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* src/lzr_pack.sv */
// lzr_pack: gathers decoded bytes into 8-byte results and holds the output register
// depends on lzr_pkg
module lzr_pack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lzr_pkg::pack_ctl_t           ctl,
	output lzr_pkg::pack_sts_t           sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lzr_pkg::OUT_W-1:0]    out_bytes,
	output logic [lzr_pkg::CNT_W-1:0]    out_count,
	output logic                         out_last
);
	import lzr_pkg::*;

	logic [OUT_W-1:0] pack_q;
	logic [CNT_W-1:0] pcnt_q;
	logic             ovld_q;
	logic [OUT_W-1:0] obytes_q;
	logic [CNT_W-1:0] ocnt_q;
	logic             olast_q;

	assign sts.full     = (pcnt_q == CNT_W'(OUT_LANES));
	assign sts.out_free = !ovld_q || out_ready;

	assign out_valid = ovld_q;
	assign out_bytes = obytes_q;
	assign out_count = ocnt_q;
	assign out_last  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q   <= '0;
			pcnt_q   <= '0;
			ovld_q   <= 1'b0;
			obytes_q <= '0;
			ocnt_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (ctl.flush) begin
				ovld_q   <= 1'b1;
				obytes_q <= pack_q;
				ocnt_q   <= pcnt_q;
				olast_q  <= ctl.last;
				pack_q   <= '0;
				pcnt_q   <= '0;
			end else begin
				if (out_ready) begin
					ovld_q <= 1'b0;
				end
				if (ctl.push) begin
					pack_q[pcnt_q[$clog2(OUT_LANES)-1:0]*8 +: 8] <= ctl.data;
					pcnt_q <= pcnt_q + 1'b1;
				end
			end
		end
	end

endmodule

/* src/lzss_rle_stream_decoder.sv */
// lzss_rle_stream_decoder: top level, token parser and copy/run sequencer
// around the 4096-byte history window; depends on lzr_pkg, lzr_ram, lzr_fill, lzr_pack
// flow: an item is taken in S_IDLE; literal and run bytes are emitted in S_RUN; each copied byte
// is a window read (S_CRD), then a write-back (S_CWR); a full result is flushed to the output
// register and S_FLUSH closes the token; the token takes longer while the output stalls
// reset, stream end and a format_mode write start a window refill
// during which s_axis_tready is low; configuration writes are still taken.
module lzss_rle_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,   // format_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // code_byte [7:0]
	input  logic        s_axis_tlast,  // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // out_bytes [63:0], out_count [67:64], zero [71:68]
	output logic        m_axis_tlast   // run_last
);
	import lzr_pkg::*;

	dec_state_t        state_q, state_n;
	logic              mode_q;
	logic [WIN_AW-1:0] wp_q;
	logic [15:0]       flag_q;
	logic [1:0]        phase_q;
	logic [7:0]        first_q;
	logic              end_q;
	logic [WIN_AW-1:0] src_q;
	logic [LEN_W-1:0]  rem_q;
	logic [7:0]        run_val_q;

	logic              s_fire;
	logic [7:0]        c;
	logic [3:0]        code, hi;
	logic [15:0]       flag_n;
	logic [1:0]        phase_n;
	logic              tok_first;
	logic              go_run, go_copy, keep_first;
	logic [7:0]        run_val_n;
	logic [LEN_W-1:0]  len_n;
	logic [WIN_AW-1:0] src_n;
	logic              restart;

	logic              fill_busy;
	logic [WIN_AW-1:0] fill_addr;
	logic [7:0]        fill_data;

	logic              ram_we;
	logic [WIN_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata, ram_rdata;

	pack_ctl_t         pctl;
	pack_sts_t         psts;
	logic [OUT_W-1:0]  o_bytes;
	logic [CNT_W-1:0]  o_cnt;

	logic              emit_run, emit_copy;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign code          = c[3:0];
	assign hi            = c[7:4];

	// token parser: decides what an accepted item starts
	always_comb begin
		flag_n     = flag_q;
		phase_n    = phase_q;
		tok_first  = 1'b0;
		go_run     = 1'b0;
		go_copy    = 1'b0;
		keep_first = 1'b0;
		run_val_n  = c;
		len_n      = LEN_W'(1);
		src_n      = {hi, first_q};
		case (phase_q)
			PH_START: begin
				if (!flag_q[9]) begin
					flag_n  = {8'h00, c} | FLAG_FILL;
					phase_n = PH_TOKEN;
				end else begin
					flag_n    = {1'b0, flag_q[15:1]};
					tok_first = 1'b1;
				end
			end
			PH_TOKEN: begin
				tok_first = 1'b1;
			end
			PH_FIRST: begin
				phase_n = PH_START;
				if (!mode_q || code != RUN_CODE) begin
					go_copy = 1'b1;
					len_n   = LEN_W'(code) + LEN_W'(3);
				end else if (hi != 4'h0) begin
					go_run    = 1'b1;
					run_val_n = first_q;
					len_n     = LEN_W'(hi) + LEN_W'(3);
				end else begin
					phase_n = PH_SECOND;
				end
			end
			default: begin
				go_run  = 1'b1;
				len_n   = LEN_W'(first_q) + LEN_W'(19);
				phase_n = PH_START;
			end
		endcase
		if (tok_first) begin
			if (flag_n[0]) begin
				go_run  = 1'b1;
				phase_n = PH_START;
			end else begin
				keep_first = 1'b1;
				phase_n    = PH_FIRST;
			end
		end
	end

	// byte emission this cycle
	assign emit_run  = (state_q == S_RUN) && (rem_q != '0) && !psts.full;
	assign emit_copy = (state_q == S_CWR);

	always_comb begin
		state_n = state_q;
		restart = 1'b0;
		pctl    = '0;
		unique case (state_q)
			S_FILL: begin
				if (!fill_busy) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_fire) begin
					if (go_run) begin
						state_n = S_RUN;
					end else if (go_copy) begin
						state_n = S_CRD;
					end else if (s_axis_tlast) begin
						restart = 1'b1;
						state_n = S_FILL;
					end
				end
			end
			S_RUN, S_CRD: begin
				if (rem_q == '0) begin
					state_n = S_FLUSH;
				end else if (psts.full) begin
					pctl.flush = psts.out_free;
				end else if (state_q == S_CRD) begin
					state_n = S_CWR;
				end
			end
			S_CWR: begin
				state_n = S_CRD;
			end
			S_FLUSH: begin
				if (psts.out_free) begin
					pctl.flush = 1'b1;
					pctl.last  = 1'b1;
					if (end_q) begin
						restart = 1'b1;
						state_n = S_FILL;
					end else begin
						state_n = S_IDLE;
					end
				end
			end
			default: state_n = S_FILL;
		endcase
		if (cfg_wr_en) begin
			restart = 1'b1;
			state_n = S_FILL;
		end
		pctl.push = emit_run || emit_copy;
		pctl.data = emit_copy ? ram_rdata : run_val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_FILL;
			mode_q    <= 1'b0;
			wp_q      <= WP_START_V1;
			flag_q    <= '0;
			phase_q   <= PH_START;
			first_q   <= '0;
			end_q     <= 1'b0;
			src_q     <= '0;
			rem_q     <= '0;
			run_val_q <= '0;
		end else begin
			state_q <= state_n;
			if (restart) begin
				flag_q  <= '0;
				phase_q <= PH_START;
				first_q <= '0;
				end_q   <= 1'b0;
				if (cfg_wr_en) begin
					mode_q <= cfg_wr_data;
					wp_q   <= cfg_wr_data ? WP_START_V3 : WP_START_V1;
				end else begin
					wp_q   <= mode_q ? WP_START_V3 : WP_START_V1;
				end
			end else begin
				if (s_fire) begin
					flag_q    <= flag_n;
					phase_q   <= phase_n;
					end_q     <= s_axis_tlast;
					run_val_q <= run_val_n;
					rem_q     <= len_n;
					src_q     <= src_n;
					if (keep_first) begin
						first_q <= c;
					end
				end
				if (emit_run || emit_copy) begin
					wp_q  <= wp_q + 1'b1;
					rem_q <= rem_q - 1'b1;
				end
				if (emit_copy) begin
					src_q <= src_q + 1'b1;
				end
			end
		end
	end

	// window write port: refill sweep or decoded bytes
	always_comb begin
		if (fill_busy) begin
			ram_we    = 1'b1;
			ram_waddr = fill_addr;
			ram_wdata = fill_data;
		end else begin
			ram_we    = pctl.push;
			ram_waddr = wp_q;
			ram_wdata = pctl.data;
		end
	end

	lzr_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (restart),
		.busy   (fill_busy),
		.addr   (fill_addr),
		.data   (fill_data)
	);

	lzr_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	lzr_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pctl),
		.sts       (psts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bytes (o_bytes),
		.out_count (o_cnt),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'h0, o_cnt, o_bytes};

endmodule
